// ===== hdl/itew_pkg.sv =====
// shared constants, types and helpers for the integer to english word token core
`default_nettype none

package itew_pkg;

  localparam int unsigned VALUE_W         = 31;
  localparam int unsigned WORD_W          = 5;
  localparam int unsigned GROUPS          = 4;
  localparam int unsigned SLOTS_PER_GROUP = 5;
  localparam int unsigned SLOTS           = GROUPS * SLOTS_PER_GROUP;
  localparam int unsigned STAGES          = 6;

  localparam int unsigned GRP_W = 10;
  localparam int unsigned HUN_W = 4;
  localparam int unsigned DEC_W = 7;
  localparam int unsigned DIG_W = 4;
  localparam int unsigned Q1_W  = 22;
  localparam int unsigned Q2_W  = 12;
  localparam int unsigned Q3_W  = 2;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t TOK_ZERO      = 5'd0;
  localparam word_t TOK_TENS_BASE = 5'd18;
  localparam word_t TOK_HUNDRED   = 5'd28;
  localparam word_t TOK_THOUSAND  = 5'd29;
  localparam word_t TOK_MILLION   = 5'd30;
  localparam word_t TOK_BILLION   = 5'd31;

  localparam logic [1:0] GRP_UNITS    = 2'd0;
  localparam logic [1:0] GRP_THOUSAND = 2'd1;
  localparam logic [1:0] GRP_MILLION  = 2'd2;
  localparam logic [1:0] GRP_BILLION  = 2'd3;

  localparam int unsigned GROUP_BASE = 1000;
  localparam int unsigned TEN        = 10;
  localparam int unsigned TEEN_LIMIT = 20;

  // floor division by reciprocal multiply
  localparam int unsigned RECIP_1000_W  = 29;
  localparam logic [RECIP_1000_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int unsigned RECIP_1000_SH = 38;
  localparam int unsigned RECIP_100_W   = 6;
  localparam logic [RECIP_100_W-1:0] RECIP_100 = 6'd41;
  localparam int unsigned RECIP_100_SH  = 12;
  localparam int unsigned RECIP_10_W    = 8;
  localparam logic [RECIP_10_W-1:0] RECIP_10 = 8'd205;
  localparam int unsigned RECIP_10_SH   = 11;

  typedef struct packed {
    logic [GRP_W-1:0] g;
    logic [HUN_W-1:0] h;
    logic [DEC_W-1:0] d;
  } grp_t;

  function automatic word_t scale_word(input logic [1:0] grp);
    word_t w;
    unique case (grp)
      GRP_BILLION:  w = TOK_BILLION;
      GRP_MILLION:  w = TOK_MILLION;
      GRP_THOUSAND: w = TOK_THOUSAND;
      default:      w = TOK_ZERO;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/integer_to_english_word_tokens_core.sv =====
// integer to english word tokens: request pipeline, group split and token emitter
// A request is taken at a clock edge with start high and busy low. Its value goes through
// six register stages that split it into billion, million, thousand and units groups and
// then into hundreds, tens and ones digits; the resulting token set is loaded into the
// emitter, whose registers then put the first token of the number on out_word.
// The emitter drives one token per cycle with out_valid high for exactly that cycle, the
// final token of a number also has out_last_word high, and the tokens of one number come
// in consecutive cycles. The receiver cannot stall, so the 1 to 16 tokens of a number go out
// back to back, and a number waiting in the last stage follows in the very next
// cycle. Requests keep entering the stage pipeline while the emitter works; busy rises
// only once all six stages are full behind a long number, so the sustained request rate
// is set by the single-token output port.
`default_nettype none

module integer_to_english_word_tokens_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [itew_pkg::VALUE_W-1:0]      in_value,
  output logic                              busy,
  output logic                              out_valid,
  output logic [itew_pkg::WORD_W-1:0]       out_word,
  output logic                              out_last_word
);

  localparam int unsigned ST  = itew_pkg::STAGES;
  localparam int unsigned NS  = itew_pkg::SLOTS;
  localparam int unsigned NG  = itew_pkg::GROUPS;
  localparam int unsigned SPG = itew_pkg::SLOTS_PER_GROUP;
  localparam int unsigned SH3 = itew_pkg::RECIP_1000_SH;

  // pipeline control
  logic [ST-1:0] vld_r, vld_nxt, mv, free;
  logic          accept;
  logic          load_ok;

  // stage payload
  logic [itew_pkg::VALUE_W-1:0] v0_r, v1_r;
  logic [itew_pkg::Q1_W-1:0]    q1_1_r, q1_2_r;
  logic [itew_pkg::Q2_W-1:0]    q2_2_r, q2_3_r;
  logic [itew_pkg::Q3_W-1:0]    q3_3_r;
  logic [itew_pkg::GRP_W-1:0]   g0_2_r, g0_3_r, g1_3_r;
  logic [itew_pkg::GRP_W-1:0]   g4_r [NG];
  itew_pkg::grp_t               g5_r [NG];

  // datapath
  logic [itew_pkg::VALUE_W+itew_pkg::RECIP_1000_W-1:0] prod1;
  logic [itew_pkg::Q1_W+itew_pkg::RECIP_1000_W-1:0]    prod2;
  logic [itew_pkg::Q2_W+itew_pkg::RECIP_1000_W-1:0]    prod3;
  logic [itew_pkg::VALUE_W:0]                           rem0;
  logic [itew_pkg::Q1_W-1:0]                            rem1;
  logic [itew_pkg::Q2_W-1:0]                            rem2;
  itew_pkg::grp_t                                       g5_nxt [NG];

  // emitter
  logic [NS-1:0]        mask_r, new_mask, low, rest;
  itew_pkg::word_t      wrd_r [NS];
  itew_pkg::word_t      new_wrd [NS];
  logic                 last_tok;

  // handshake and stage advance
  always_comb begin
    load_ok      = (mask_r == '0) || last_tok;
    mv[ST-1]     = vld_r[ST-1] && load_ok;
    free[ST-1]   = !vld_r[ST-1] || mv[ST-1];
    for (int k = ST - 2; k >= 0; k--) begin
      mv[k]   = vld_r[k] && free[k+1];
      free[k] = !vld_r[k] || mv[k];
    end
    busy       = !free[0];
    accept     = start && free[0];
    vld_nxt[0] = accept || (vld_r[0] && !mv[0]);
    for (int k = 1; k < ST; k++) begin
      vld_nxt[k] = mv[k-1] || (vld_r[k] && !mv[k]);
    end
  end

  // group split by reciprocal multiply
  always_comb begin
    prod1 = (itew_pkg::VALUE_W+itew_pkg::RECIP_1000_W)'(v0_r)
          * (itew_pkg::VALUE_W+itew_pkg::RECIP_1000_W)'(itew_pkg::RECIP_1000);
    prod2 = (itew_pkg::Q1_W+itew_pkg::RECIP_1000_W)'(q1_1_r)
          * (itew_pkg::Q1_W+itew_pkg::RECIP_1000_W)'(itew_pkg::RECIP_1000);
    prod3 = (itew_pkg::Q2_W+itew_pkg::RECIP_1000_W)'(q2_2_r)
          * (itew_pkg::Q2_W+itew_pkg::RECIP_1000_W)'(itew_pkg::RECIP_1000);
    rem0  = (itew_pkg::VALUE_W+1)'(v1_r)
          - (itew_pkg::VALUE_W+1)'(q1_1_r) * (itew_pkg::VALUE_W+1)'(itew_pkg::GROUP_BASE);
    rem1  = q1_2_r - itew_pkg::Q1_W'(q2_2_r) * itew_pkg::Q1_W'(itew_pkg::GROUP_BASE);
    rem2  = q2_3_r - itew_pkg::Q2_W'(q3_3_r) * itew_pkg::Q2_W'(itew_pkg::GROUP_BASE);
  end

  // hundreds digit and value over ten for each group
  always_comb begin
    logic [itew_pkg::GRP_W+itew_pkg::RECIP_100_W-1:0] hp;
    logic [itew_pkg::GRP_W+itew_pkg::RECIP_10_W-1:0]  dp;
    hp = '0;
    dp = '0;
    for (int i = 0; i < NG; i++) begin
      hp = (itew_pkg::GRP_W+itew_pkg::RECIP_100_W)'(g4_r[i])
         * (itew_pkg::GRP_W+itew_pkg::RECIP_100_W)'(itew_pkg::RECIP_100);
      dp = (itew_pkg::GRP_W+itew_pkg::RECIP_10_W)'(g4_r[i])
         * (itew_pkg::GRP_W+itew_pkg::RECIP_10_W)'(itew_pkg::RECIP_10);
      g5_nxt[i].g = g4_r[i];
      g5_nxt[i].h = hp[itew_pkg::RECIP_100_SH +: itew_pkg::HUN_W];
      g5_nxt[i].d = dp[itew_pkg::RECIP_10_SH +: itew_pkg::DEC_W];
    end
  end

  // token slots: digit, hundred, teen or tens, ones, scale for each group
  always_comb begin
    logic [itew_pkg::DEC_W-1:0] tt;
    logic [itew_pkg::GRP_W-1:0] oo;
    logic [itew_pkg::DIG_W-1:0] t;
    logic [itew_pkg::DIG_W-1:0] o;
    logic [itew_pkg::DEC_W-1:0] r;
    logic                       all_zero;
    int unsigned                s;
    all_zero = 1'b1;
    tt = '0;
    oo = '0;
    t  = '0;
    o  = '0;
    r  = '0;
    s  = 0;
    for (int i = 0; i < NG; i++) begin
      if (g5_r[i].g != '0) begin
        all_zero = 1'b0;
      end
    end
    for (int i = 0; i < NG; i++) begin
      tt = g5_r[i].d - itew_pkg::DEC_W'(g5_r[i].h) * itew_pkg::DEC_W'(itew_pkg::TEN);
      oo = g5_r[i].g - itew_pkg::GRP_W'(g5_r[i].d) * itew_pkg::GRP_W'(itew_pkg::TEN);
      t  = tt[itew_pkg::DIG_W-1:0];
      o  = oo[itew_pkg::DIG_W-1:0];
      r  = itew_pkg::DEC_W'(t) * itew_pkg::DEC_W'(itew_pkg::TEN) + itew_pkg::DEC_W'(o);
      s  = (NG - 1 - i) * SPG;
      new_wrd[s]    = itew_pkg::WORD_W'(g5_r[i].h);
      new_mask[s]   = g5_r[i].h != '0;
      new_wrd[s+1]  = itew_pkg::TOK_HUNDRED;
      new_mask[s+1] = g5_r[i].h != '0;
      if (r < itew_pkg::DEC_W'(itew_pkg::TEEN_LIMIT)) begin
        new_wrd[s+2] = itew_pkg::WORD_W'(r);
      end else begin
        new_wrd[s+2] = itew_pkg::TOK_TENS_BASE + itew_pkg::WORD_W'(t);
      end
      // zero alone spells as the units teen slot
      new_mask[s+2] = (r != '0) || ((i == 0) && all_zero);
      new_wrd[s+3]  = itew_pkg::WORD_W'(o);
      new_mask[s+3] = (r >= itew_pkg::DEC_W'(itew_pkg::TEEN_LIMIT)) && (o != '0);
      new_wrd[s+4]  = itew_pkg::scale_word(2'(i));
      new_mask[s+4] = (g5_r[i].g != '0) && (i != 0);
    end
  end

  // emitter pick
  always_comb begin
    low           = mask_r & (~mask_r + NS'(1));
    rest          = mask_r & ~low;
    last_tok      = (mask_r != '0) && (rest == '0);
    out_valid     = mask_r != '0;
    out_last_word = last_tok;
    out_word      = '0;
    for (int i = 0; i < NS; i++) begin
      out_word = out_word | ({itew_pkg::WORD_W{low[i]}} & wrd_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      mask_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (mv[ST-1]) begin
        mask_r <= new_mask;
      end else begin
        mask_r <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v0_r <= in_value;
    end
    if (mv[0]) begin
      v1_r   <= v0_r;
      q1_1_r <= prod1[SH3 +: itew_pkg::Q1_W];
    end
    if (mv[1]) begin
      g0_2_r <= rem0[itew_pkg::GRP_W-1:0];
      q1_2_r <= q1_1_r;
      q2_2_r <= prod2[SH3 +: itew_pkg::Q2_W];
    end
    if (mv[2]) begin
      g0_3_r <= g0_2_r;
      g1_3_r <= rem1[itew_pkg::GRP_W-1:0];
      q2_3_r <= q2_2_r;
      q3_3_r <= prod3[SH3 +: itew_pkg::Q3_W];
    end
    if (mv[3]) begin
      g4_r[0] <= g0_3_r;
      g4_r[1] <= g1_3_r;
      g4_r[2] <= rem2[itew_pkg::GRP_W-1:0];
      g4_r[3] <= itew_pkg::GRP_W'(q3_3_r);
    end
    if (mv[4]) begin
      for (int i = 0; i < NG; i++) begin
        g5_r[i] <= g5_nxt[i];
      end
    end
    if (mv[ST-1]) begin
      for (int i = 0; i < NS; i++) begin
        wrd_r[i] <= new_wrd[i];
      end
    end
  end

  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_word |=> out_valid)
    else $error("token run broken before its last token");

  a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> vld_r[0])
    else $error("taken request missing from first stage");

  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (vld_r == '1) && !load_ok)
    else $error("busy without a full stalled pipeline");

  a_load_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_word |-> !mv[ST-1])
    else $error("emitter reloaded in the middle of a run");

endmodule

`default_nettype wire
